// File: hw/rtl/gf_2_16_arithmetic_unit_core_macros.svh
// ----------------------------------------------------------------------------
// gf16 assertion macros
// concurrent check wrappers shared by the gf(2^16) unit rtl
// ----------------------------------------------------------------------------
`ifndef GF_2_16_ARITHMETIC_UNIT_CORE_MACROS_SVH
`define GF_2_16_ARITHMETIC_UNIT_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define GF16_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gf16 same-cycle check failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define GF16_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gf16 next-cycle check failed");

`endif

// File: hw/rtl/gf16_pkg.sv
// ----------------------------------------------------------------------------
// gf16 package
// field constants, operation codes and shared types of the gf(2^16) unit
// ----------------------------------------------------------------------------
package gf16_pkg;

	localparam int unsigned ELEM_W = 16;
	localparam int unsigned EXP_W  = 32;
	localparam int unsigned FUNC_W = 3;

	// x^16+x^12+x^3+x+1, bit 16 implied by the shift-out
	localparam logic [ELEM_W-1:0] GF_POLY_LO = 16'h100B;
	// order of the multiplicative group
	localparam logic [ELEM_W-1:0] GF_ORDER   = 16'hFFFF;

	localparam int unsigned LOG_DEPTH  = 65536;
	localparam int unsigned ALOG_DEPTH = 65535;

	typedef enum logic [FUNC_W-1:0] {
		FN_MUL     = 3'd0,
		FN_DIV     = 3'd1,
		FN_INV     = 3'd2,
		FN_POW     = 3'd3,
		FN_MUL_POW = 3'd4,
		FN_LOG     = 3'd5
	} func_t;

	// which source drives the result word
	typedef enum logic [1:0] {
		RS_ZERO = 2'd0,
		RS_ALOG = 2'd1,
		RS_LOG  = 2'd2
	} res_sel_t;

	typedef enum logic {
		FS_FILL = 1'b0,
		FS_RUN  = 1'b1
	} fill_state_t;

	// table write issued by the fill sequencer
	typedef struct packed {
		logic              we;
		logic [ELEM_W-1:0] idx;
		logic [ELEM_W-1:0] elem;
	} fill_wr_t;

endpackage

// File: hw/rtl/gf16_ram.sv
// ----------------------------------------------------------------------------
// gf16 generic ram
// one write port, two read ports, registered reads with a shared enable
// ----------------------------------------------------------------------------
module gf16_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
	output logic [WIDTH-1:0]         rd_data_a,
	output logic [WIDTH-1:0]         rd_data_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a <= mem[rd_addr_a];
			rd_data_b <= mem[rd_addr_b];
		end
	end

endmodule

// File: hw/rtl/gf16_fill.sv
// ----------------------------------------------------------------------------
// gf16 table fill
// walks alpha^i after reset and writes the log and antilog tables
// ----------------------------------------------------------------------------
module gf16_fill import gf16_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	output fill_wr_t wr,
	output logic     done
);

	fill_state_t       state_q;
	fill_state_t       state_nxt;
	logic [ELEM_W-1:0] idx_q;
	logic [ELEM_W-1:0] elem_q;
	logic [ELEM_W-1:0] elem_nxt;

	// multiply by alpha: shift and fold the top bit back through the polynomial
	assign elem_nxt = {elem_q[ELEM_W-2:0], 1'b0} ^ (elem_q[ELEM_W-1] ? GF_POLY_LO : '0);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			FS_FILL: begin
				if (idx_q == GF_ORDER - 16'd1) begin
					state_nxt = FS_RUN;
				end
			end
			FS_RUN:  state_nxt = FS_RUN;
			default: state_nxt = FS_FILL;
		endcase
	end

	always_comb begin
		wr.idx  = idx_q;
		wr.elem = elem_q;
		case (state_q)
			FS_FILL: begin
				wr.we = 1'b1;
				done  = 1'b0;
			end
			FS_RUN: begin
				wr.we = 1'b0;
				done  = 1'b1;
			end
			default: begin
				wr.we = 1'b0;
				done  = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_FILL;
			idx_q   <= '0;
			elem_q  <= 16'd1;
		end else begin
			state_q <= state_nxt;
			if (state_q == FS_FILL) begin
				idx_q  <= idx_q + 16'd1;
				elem_q <= elem_nxt;
			end
		end
	end

endmodule

// File: hw/rtl/gf_2_16_arithmetic_unit_core.sv
// ----------------------------------------------------------------------------
// gf(2^16) arithmetic unit
// mul, div, inv, alpha^e, a*alpha^e and discrete log through log/antilog tables
// ----------------------------------------------------------------------------
// an accepted input beat passes the registered stages s1 through s5 on its way to its output beat
// throughput: one beat per cycle while m_axis_tready is high, set by the registered table read ports
// after reset the fill sequencer writes both tables; s_axis_tready stays low until it is done
// reset clears the fill sequencer and all pipeline valid bits
// ----------------------------------------------------------------------------
`include "gf_2_16_arithmetic_unit_core_macros.svh"

module gf_2_16_arithmetic_unit_core import gf16_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // operand_a[15:0], operand_b[31:16], exponent[63:32]
	input  logic [2:0]  s_axis_tuser,  // func[2:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // result[15:0]
	output logic        m_axis_tuser   // log_undefined
);

	// table fill after reset
	fill_wr_t wr;
	logic     fill_done;

	gf16_fill u_fill (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.done   (fill_done)
	);

	// per-stage advance: a stage moves when it is empty or the next one moves
	logic adv1, adv2, adv3, adv4, adv5;
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;

	always_comb begin
		adv5 = !valid_s5 || m_axis_tready;
		adv4 = !valid_s4 || adv5;
		adv3 = !valid_s3 || adv4;
		adv2 = !valid_s2 || adv3;
		adv1 = !valid_s1 || adv2;
	end

	assign s_axis_tready = adv1 && fill_done;

	logic in_beat;
	assign in_beat = s_axis_tvalid && s_axis_tready;

	// input fields
	logic [ELEM_W-1:0] in_a;
	logic [ELEM_W-1:0] in_b;
	logic [EXP_W-1:0]  in_e;
	assign in_a = s_axis_tdata[15:0];
	assign in_b = s_axis_tdata[31:16];
	assign in_e = s_axis_tdata[63:32];

	// log table: both operands looked up on entry, data lands with stage 1
	logic [ELEM_W-1:0] la_rd;
	logic [ELEM_W-1:0] lb_rd;

	gf16_ram #(
		.WIDTH (ELEM_W),
		.DEPTH (LOG_DEPTH)
	) u_log_ram (
		.clk       (clk),
		.we        (wr.we),
		.wr_addr   (wr.elem),
		.wr_data   (wr.idx),
		.rd_en     (adv1),
		.rd_addr_a (in_a),
		.rd_addr_b (in_b),
		.rd_data_a (la_rd),
		.rd_data_b (lb_rd)
	);

	// stage 1: decode, zero tests, first fold of the exponent
	// 2^16 = 1 mod 65535, so e mod 65535 = (hi + lo) folded
	func_t           func_s1;
	logic            anz_s1;
	logic            bnz_s1;
	logic [ELEM_W:0] efold_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv1) begin
			valid_s1 <= in_beat;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			func_s1  <= func_t'(s_axis_tuser);
			anz_s1   <= (in_a != '0);
			bnz_s1   <= (in_b != '0);
			efold_s1 <= {1'b0, in_e[31:16]} + {1'b0, in_e[15:0]};
		end
	end

	// stage 2: finish the exponent reduction, hold the logs
	logic [ELEM_W-1:0] efold2;
	logic [ELEM_W-1:0] em_s2;
	logic [ELEM_W-1:0] la_s2;
	logic [ELEM_W-1:0] lb_s2;
	func_t             func_s2;
	logic              anz_s2;
	logic              bnz_s2;

	// hi + lo <= 0x1fffe, so the second fold fits 16 bits
	assign efold2 = efold_s1[ELEM_W-1:0] + {{(ELEM_W-1){1'b0}}, efold_s1[ELEM_W]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			em_s2   <= (efold2 == GF_ORDER) ? '0 : efold2;
			// log of zero reads as zero, that table entry is never written
			la_s2   <= anz_s1 ? la_rd : '0;
			lb_s2   <= bnz_s1 ? lb_rd : '0;
			func_s2 <= func_s1;
			anz_s2  <= anz_s1;
			bnz_s2  <= bnz_s1;
		end
	end

	// stage 3: exponent sum per operation and result source
	logic [ELEM_W:0]   sum_nxt;
	res_sel_t          sel_nxt;
	logic              undef_nxt;
	logic [ELEM_W:0]   sum_s3;
	res_sel_t          sel_s3;
	logic              undef_s3;
	logic [ELEM_W-1:0] la_s3;

	always_comb begin
		sum_nxt   = '0;
		sel_nxt   = RS_ZERO;
		undef_nxt = 1'b0;
		case (func_s2)
			FN_MUL: begin
				sum_nxt = {1'b0, la_s2} + {1'b0, lb_s2};
				sel_nxt = (anz_s2 && bnz_s2) ? RS_ALOG : RS_ZERO;
			end
			FN_DIV: begin
				// 65535 - lb is ~lb for a log in 0..65534
				sum_nxt = {1'b0, la_s2} + {1'b0, ~lb_s2};
				sel_nxt = (anz_s2 && bnz_s2) ? RS_ALOG : RS_ZERO;
			end
			FN_INV: begin
				sum_nxt = {1'b0, ~la_s2};
				sel_nxt = anz_s2 ? RS_ALOG : RS_ZERO;
			end
			FN_POW: begin
				sum_nxt = {1'b0, em_s2};
				sel_nxt = RS_ALOG;
			end
			FN_MUL_POW: begin
				sum_nxt = {1'b0, la_s2} + {1'b0, em_s2};
				sel_nxt = anz_s2 ? RS_ALOG : RS_ZERO;
			end
			FN_LOG: begin
				sel_nxt   = anz_s2 ? RS_LOG : RS_ZERO;
				undef_nxt = !anz_s2;
			end
			default: begin
				sel_nxt = RS_ZERO;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			sum_s3   <= sum_nxt;
			sel_s3   <= sel_nxt;
			undef_s3 <= undef_nxt;
			la_s3    <= la_s2;
		end
	end

	// stage 4: reduce mod 65535 (sum < 2*65535) and read the antilog table
	logic [ELEM_W-1:0] alog_idx;
	logic [ELEM_W:0]   sum_red;
	logic [ELEM_W-1:0] alog_rd;
	res_sel_t          sel_s4;
	logic              undef_s4;
	logic [ELEM_W-1:0] la_s4;

	assign sum_red  = sum_s3 - {1'b0, GF_ORDER};
	assign alog_idx = (sum_s3 >= {1'b0, GF_ORDER}) ? sum_red[ELEM_W-1:0] : sum_s3[ELEM_W-1:0];

	gf16_ram #(
		.WIDTH (ELEM_W),
		.DEPTH (ALOG_DEPTH)
	) u_alog_ram (
		.clk       (clk),
		.we        (wr.we),
		.wr_addr   (wr.idx),
		.wr_data   (wr.elem),
		.rd_en     (adv4),
		.rd_addr_a (alog_idx),
		.rd_addr_b ('0),
		.rd_data_a (alog_rd),
		.rd_data_b ()
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (adv4) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv4) begin
			sel_s4   <= sel_s3;
			undef_s4 <= undef_s3;
			la_s4    <= la_s3;
		end
	end

	// stage 5: output register, pick the result source
	logic [ELEM_W-1:0] res_nxt;
	logic [ELEM_W-1:0] result_s5;
	logic              undef_s5;

	always_comb begin
		case (sel_s4)
			RS_ALOG: res_nxt = alog_rd;
			RS_LOG:  res_nxt = la_s4;
			default: res_nxt = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (adv5) begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv5) begin
			result_s5 <= res_nxt;
			undef_s5  <= undef_s4;
		end
	end

	assign m_axis_tvalid = valid_s5;
	assign m_axis_tdata  = result_s5;
	assign m_axis_tuser  = undef_s5;

	// checks
	`GF16_ASSERT_IMP(a_no_beat_during_fill, s_axis_tvalid && s_axis_tready, fill_done)
	`GF16_ASSERT_IMP(a_fill_write_only_in_fill, wr.we, !fill_done)
	`GF16_ASSERT_IMP(a_exp_reduced, valid_s2, em_s2 != GF_ORDER)
	`GF16_ASSERT_IMP(a_alog_index_in_range, valid_s3 && adv4, alog_idx != GF_ORDER)
	`GF16_ASSERT_IMP(a_undef_gives_zero, valid_s5 && undef_s5, result_s5 == '0)
	`GF16_ASSERT_NXT(a_accept_fills_s1, s_axis_tvalid && s_axis_tready, valid_s1)

endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// gf(2^16) arithmetic unit testbench
// drives random and corner-case operations into the unit and checks every
// output beat against a table-based field model kept in a scoreboard
// ----------------------------------------------------------------------------
module testbench;
	import gf16_pkg::*;

	// tuser codes the unit leaves unassigned, they must give zero
	localparam logic [FUNC_W-1:0] FN_SPARE_6 = 3'd6;
	localparam logic [FUNC_W-1:0] FN_SPARE_7 = 3'd7;

	localparam int unsigned PIPE_LAT     = 5;
	localparam int unsigned LONG_HOLD    = 400;
	localparam int unsigned RANDOM_BEATS = 1300;
	localparam int unsigned HOLD_AT      = 400;
	localparam int unsigned DRAIN_AT     = 750;
	localparam int unsigned STEADY_AT    = 1100;

	typedef struct packed {
		logic [ELEM_W-1:0] value;
		logic              log_undef;
	} gf_result_t;

	// field model plus the queue of results still owed by the unit
	class gf_scoreboard;
		bit [ELEM_W-1:0] antilog_tab [ALOG_DEPTH];
		bit [ELEM_W-1:0] log_tab [LOG_DEPTH];
		gf_result_t      owed_results [$];
		int unsigned     ops_seen [8];
		int unsigned     results_checked;
		int unsigned     mismatches;

		function new();
			bit [ELEM_W:0] x;
			x = 17'd1;
			log_tab[0] = '0;
			for (int i = 0; i < ALOG_DEPTH; i++) begin
				antilog_tab[i] = x[ELEM_W-1:0];
				log_tab[x[ELEM_W-1:0]] = 16'(i);
				x = x << 1;
				// reduce by x^16+x^12+x^3+x+1
				if (x[ELEM_W]) x = x ^ {1'b1, GF_POLY_LO};
			end
		endfunction

		function bit [ELEM_W-1:0] alpha_pow(bit [EXP_W-1:0] e);
			return antilog_tab[e % GF_ORDER];
		endfunction

		function gf_result_t field_op_result(logic [FUNC_W-1:0] fn, bit [ELEM_W-1:0] a,
			bit [ELEM_W-1:0] b, bit [EXP_W-1:0] e);
			gf_result_t  r;
			bit [31:0]   la;
			bit [31:0]   lb;
			r  = '0;
			la = log_tab[a];
			lb = log_tab[b];
			case (fn)
				FN_MUL:     if (a != 0 && b != 0) r.value = alpha_pow(la + lb);
				FN_DIV:     if (a != 0 && b != 0) r.value = alpha_pow(la + GF_ORDER - lb);
				FN_INV:     if (a != 0) r.value = alpha_pow(GF_ORDER - la);
				FN_POW:     r.value = alpha_pow(e);
				FN_MUL_POW: if (a != 0) r.value = alpha_pow(la + e % GF_ORDER);
				FN_LOG: begin
					if (a != 0) r.value = log_tab[a];
					else r.log_undef = 1'b1;
				end
				default: ;
			endcase
			return r;
		endfunction

		function void note_operation(logic [FUNC_W-1:0] fn, bit [ELEM_W-1:0] a,
			bit [ELEM_W-1:0] b, bit [EXP_W-1:0] e);
			ops_seen[fn]++;
			owed_results.push_back(field_op_result(fn, a, b, e));
		endfunction

		function void check_result(logic [ELEM_W-1:0] value, logic log_undef);
			gf_result_t want;
			if (owed_results.size() == 0) begin
				mismatches++;
				$display("%0t: output beat with nothing owed, actual result %h undef %b",
					$time, value, log_undef);
				return;
			end
			want = owed_results.pop_front();
			results_checked++;
			if (value !== want.value) begin
				mismatches++;
				$display("%0t: result mismatch, expected %h actual %h",
					$time, want.value, value);
			end
			if (log_undef !== want.log_undef) begin
				mismatches++;
				$display("%0t: log_undefined mismatch, expected %b actual %b",
					$time, want.log_undef, log_undef);
			end
		endfunction

		function int unsigned pending();
			return owed_results.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata;   // operand_a[15:0], operand_b[31:16], exponent[63:32]
	logic [2:0]  s_axis_tuser;   // func[2:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;   // result[15:0]
	logic        m_axis_tuser;   // log_undefined

	gf_scoreboard sb = new();

	// shared knobs between the input and output processes
	bit idle_en       = 1'b1;
	bit long_hold_req = 1'b0;

	gf_2_16_arithmetic_unit_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// generous ceiling: table fill plus every beat at its worst stalls
	initial begin
		#2000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// offer one beat and hold it until the unit takes it
	task automatic send_op(logic [FUNC_W-1:0] fn, logic [ELEM_W-1:0] a,
		logic [ELEM_W-1:0] b, logic [EXP_W-1:0] e);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= fn;
		s_axis_tdata  <= {e, b, a};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_operation(fn, a, b, e);
		// random input bubble after some beats
		if (idle_en && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= {$urandom, $urandom};
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	// bias toward the values where the log tables wrap or go undefined
	function automatic logic [ELEM_W-1:0] pick_element();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return 16'h0001;
			2:       return '1;
			3:       return 16'h0002;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [EXP_W-1:0] pick_exponent();
		case ($urandom_range(0, 7))
			0:       return 32'($urandom_range(0, 65536)) * GF_ORDER
				+ 32'($urandom_range(0, 2)) - 1;
			1:       return '1 - 32'($urandom_range(0, 3));
			2:       return 32'($urandom_range(0, 70000));
			default: return $urandom;
		endcase
	endfunction

	// output side: pick ready pattern, counting its own cycles
	initial begin
		forever begin
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (idle_en && $urandom_range(0, 3) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	// every accepted output beat is checked against the oldest owed result
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tuser);
	end

	initial begin
		logic [FUNC_W-1:0] fn;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= FN_MUL;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// corner cases: zero operands, all-ones, exponent wrap, log of zero
		send_op(FN_MUL, 16'h0000, 16'h1234, $urandom);
		send_op(FN_MUL, 16'hFFFF, 16'h0000, $urandom);
		send_op(FN_MUL, 16'hFFFF, 16'hFFFF, '1);
		send_op(FN_MUL, 16'h0001, 16'h0001, '0);
		send_op(FN_MUL, 16'h8000, 16'h0002, $urandom);
		send_op(FN_DIV, 16'h1234, 16'h0000, $urandom);
		send_op(FN_DIV, 16'h0000, 16'h0055, $urandom);
		send_op(FN_DIV, 16'hFFFF, 16'hFFFF, $urandom);
		send_op(FN_DIV, 16'h0001, 16'hFFFF, $urandom);
		send_op(FN_INV, 16'h0000, 16'($urandom), $urandom);
		send_op(FN_INV, 16'h0001, 16'($urandom), $urandom);
		send_op(FN_INV, 16'hFFFF, 16'($urandom), $urandom);
		send_op(FN_POW, 16'($urandom), 16'($urandom), 32'd0);
		send_op(FN_POW, 16'($urandom), 16'($urandom), 32'd65535);
		send_op(FN_POW, 16'($urandom), 16'($urandom), 32'd65534);
		send_op(FN_POW, 16'($urandom), 16'($urandom), 32'hFFFF_FFFF);
		send_op(FN_MUL_POW, 16'h0000, 16'($urandom), 32'd5);
		send_op(FN_MUL_POW, 16'hFFFF, 16'($urandom), 32'hFFFF_FFFF);
		send_op(FN_MUL_POW, 16'h0001, 16'($urandom), 32'd65535);
		send_op(FN_LOG, 16'h0000, 16'($urandom), $urandom);
		send_op(FN_LOG, 16'h0001, 16'($urandom), $urandom);
		send_op(FN_LOG, 16'hFFFF, 16'($urandom), $urandom);
		send_op(FN_LOG, 16'h0002, 16'($urandom), $urandom);
		send_op(FN_SPARE_6, '1, '1, '1);
		send_op(FN_SPARE_7, '1, '1, '1);

		// sender pause: let the unit drain completely
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);

		for (int i = 0; i < RANDOM_BEATS; i++) begin
			if (i == HOLD_AT) long_hold_req = 1'b1;
			if (i == DRAIN_AT) begin
				s_axis_tvalid <= 1'b0;
				do @(posedge clk); while (sb.pending() != 0);
			end
			// last stretch runs back to back on both sides
			if (i == STEADY_AT) idle_en = 1'b0;
			if ($urandom_range(0, 19) == 0)
				fn = FUNC_W'($urandom_range(FN_SPARE_6, FN_SPARE_7));
			else
				fn = FUNC_W'($urandom_range(FN_MUL, FN_LOG));
			send_op(fn, pick_element(), pick_element(), pick_exponent());
		end

		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (PIPE_LAT * 4) @(posedge clk);

		$display("ran %0d ops: mul %0d div %0d inv %0d pow %0d mul_pow %0d log %0d spare %0d",
			sb.results_checked, sb.ops_seen[FN_MUL], sb.ops_seen[FN_DIV],
			sb.ops_seen[FN_INV], sb.ops_seen[FN_POW], sb.ops_seen[FN_MUL_POW],
			sb.ops_seen[FN_LOG], sb.ops_seen[FN_SPARE_6] + sb.ops_seen[FN_SPARE_7]);
		$display("random stalls both sides, one %0d-cycle output hold-off, %0d mismatches",
			LONG_HOLD, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
